// ===== src/ohpc_pkg.sv =====
`timescale 1ns / 1ps

package ohpc_pkg;

  // Default table geometry.
  localparam int DEF_MAX_SLOTS = 1024;
  localparam int DEF_MAX_IDS   = 1024;

  // Fixed field widths of the ports.
  localparam int TABLE_SIZE_W   = 11;
  localparam int PROBE_STEP_W   = 10;
  localparam int ID_FIELD_W     = 10;
  localparam int HASH_FIELD_W   = 10;
  localparam int PASSED_FIELD_W = 10;
  localparam int SLOT_FIELD_W   = 10;
  localparam int TOTAL_W        = 40;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 11;

  // Register reset values and limits.
  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1024;
  localparam logic [PROBE_STEP_W-1:0] PROBE_STEP_RESET = 10'd1;
  localparam int MIN_SIZE  = 2;
  localparam int FIELD_MAX = (1 << PASSED_FIELD_W) - 1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TABLE_SIZE = 1'b0,
    CFG_PROBE_STEP = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_HASH = 2'd2,
    ST_BAD_ID   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // A classified word as it travels from the front to the back.
  typedef struct packed {
    kind_t                   kind;
    status_t                 status;
    logic [ID_FIELD_W-1:0]   id;
    logic [HASH_FIELD_W-1:0] hash;
  } item_t;

  // One finished result word.
  typedef struct packed {
    logic [PASSED_FIELD_W-1:0] probes_passed;
    logic [SLOT_FIELD_W-1:0]   slot;
    status_t                   status;
    logic [TOTAL_W-1:0]        total;
  } result_t;

endpackage

// ===== src/ohpc_front.sv =====
`timescale 1ns / 1ps

module ohpc_front #(
  parameter int MAX_IDS = ohpc_pkg::DEF_MAX_IDS,
  parameter int SZ_W    = 11
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 op,
  input  logic [ohpc_pkg::ID_FIELD_W-1:0]      id,
  input  logic [ohpc_pkg::HASH_FIELD_W-1:0]    hash,
  input  logic [SZ_W-1:0]                      eff_size,
  input  logic                                 hold,
  output logic                                 q_valid,
  output ohpc_pkg::item_t                      q_item,
  input  logic                                 q_pop
);

  localparam int QD   = ohpc_pkg::QUEUE_DEPTH;
  localparam int QP_W = $clog2(QD);

  ohpc_pkg::item_t q_mem [QD];
  ohpc_pkg::item_t item_in;
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;
  logic            accept;
  logic            id_ok;
  logic            hash_ok;

  assign full   = hold || (count == (QP_W+1)'(QD));
  assign accept = push && !full;

  assign id_ok   = 32'(id) < MAX_IDS;
  assign hash_ok = 32'(hash) < 32'(eff_size);

  // Sort each word into the work the back has to do, or a rejection.
  always_comb begin
    item_in.id     = id;
    item_in.hash   = hash;
    item_in.status = ohpc_pkg::ST_OK;
    item_in.kind   = ohpc_pkg::KIND_INSERT;
    if (ohpc_pkg::op_t'(op) == ohpc_pkg::OP_DELETE) begin
      if (id_ok) begin
        item_in.kind = ohpc_pkg::KIND_DELETE;
      end else begin
        item_in.kind   = ohpc_pkg::KIND_REJECT;
        item_in.status = ohpc_pkg::ST_BAD_ID;
      end
    end else if (!hash_ok) begin
      item_in.kind   = ohpc_pkg::KIND_REJECT;
      item_in.status = ohpc_pkg::ST_BAD_HASH;
    end else if (!id_ok) begin
      item_in.kind   = ohpc_pkg::KIND_REJECT;
      item_in.status = ohpc_pkg::ST_BAD_ID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QP_W+1)'(accept) - (QP_W+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = q_mem[rd_ptr];

endmodule

// ===== src/ohpc_step_mod.sv =====
`timescale 1ns / 1ps

module ohpc_step_mod #(
  parameter int SZ_W   = 11,
  parameter int SLOT_W = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [ohpc_pkg::PROBE_STEP_W-1:0]   probe_step,
  input  logic [SZ_W-1:0]                     eff_size,
  output logic [SLOT_W-1:0]                   step,
  output logic                                busy
);

  localparam int DW    = ohpc_pkg::PROBE_STEP_W;
  localparam int CNT_W = $clog2(DW);
  localparam int REM_W = SZ_W + 1;

  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] rem_next;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  always_comb begin
    rem_shift = {rem[REM_W-2:0], probe_step[CNT_W'(DW-1) - cnt]};
    if (rem_shift >= REM_W'(eff_size)) begin
      rem_next = rem_shift - REM_W'(eff_size);
    end else begin
      rem_next = rem_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DW-1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign step = SLOT_W'(rem);

endmodule

// ===== src/ohpc_back.sv =====
`timescale 1ns / 1ps

module ohpc_back #(
  parameter int MAX_SLOTS = ohpc_pkg::DEF_MAX_SLOTS,
  parameter int MAX_IDS   = ohpc_pkg::DEF_MAX_IDS,
  parameter int SZ_W      = 11,
  parameter int SLOT_W    = 10,
  parameter int ID_W      = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  ohpc_pkg::item_t         q_item,
  output logic                    q_pop,
  input  logic [SZ_W-1:0]         eff_size,
  input  logic [SLOT_W-1:0]       step,
  output logic                    clearing,
  input  logic                    pop,
  output logic                    empty,
  output ohpc_pkg::result_t       res
);

  localparam int CLR_N   = (MAX_SLOTS > MAX_IDS) ? MAX_SLOTS : MAX_IDS;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam int SUM_W   = SLOT_W + 1;
  localparam int TOT_W   = ohpc_pkg::TOTAL_W;
  localparam int PASS_W  = ohpc_pkg::PASSED_FIELD_W;
  localparam int SLOTF_W = ohpc_pkg::SLOT_FIELD_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DEL   = 5'b00100,
    S_WALK  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CLR_W-1:0] clr_addr;

  logic              busy_mem   [MAX_SLOTS];
  logic              live_mem   [MAX_IDS];
  logic [SLOT_W-1:0] idslot_mem [MAX_IDS];

  logic              busy_q;
  logic              live_q;
  logic [SLOT_W-1:0] idslot_q;

  logic [SLOT_W-1:0] busy_ra;
  logic [SLOT_W-1:0] busy_wa;
  logic              busy_we;
  logic              busy_wd;
  logic [ID_W-1:0]   id_ra;
  logic [ID_W-1:0]   id_wa;
  logic              live_we;
  logic              live_wd;
  logic              idslot_we;

  logic [SLOT_W-1:0] head_hash_idx;
  logic [ID_W-1:0]   head_id_idx;

  logic [SLOT_W-1:0] pos_chk;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] pos_nxt;
  logic [SUM_W-1:0]  pos_sum;
  logic [SZ_W-1:0]   passed;
  logic [ID_W-1:0]   cur_id;

  logic [TOT_W:0]    total_sum;
  logic [TOT_W-1:0]  total_sat;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_next;
  logic [PASS_W-1:0] passed_sat;

  ohpc_pkg::result_t hold_res;
  ohpc_pkg::result_t hold_res_next;
  logic              out_valid;
  logic              out_load;

  assign head_hash_idx = SLOT_W'(32'(q_item.hash));
  assign head_id_idx   = ID_W'(32'(q_item.id));

  // Next probe position; both terms are below the size, so one subtract wraps it.
  assign pos_sum = SUM_W'(pos_chk) + SUM_W'(step);
  assign pos_nxt = (pos_sum >= SUM_W'(eff_size)) ? SLOT_W'(pos_sum - SUM_W'(eff_size))
                                                 : SLOT_W'(pos_sum);

  assign total_sum  = (TOT_W+1)'(total) + (TOT_W+1)'(passed);
  assign total_sat  = total_sum[TOT_W] ? {TOT_W{1'b1}} : total_sum[TOT_W-1:0];
  assign passed_sat = (32'(passed) > ohpc_pkg::FIELD_MAX) ? PASS_W'(ohpc_pkg::FIELD_MAX)
                                                          : PASS_W'(passed);

  assign out_load = (state == S_HOLD) && (!out_valid || pop);

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    busy_we       = 1'b0;
    busy_wa       = pos_chk;
    busy_wd       = 1'b0;
    busy_ra       = pos_nxt;
    id_ra         = head_id_idx;
    id_wa         = cur_id;
    live_we       = 1'b0;
    live_wd       = 1'b0;
    idslot_we     = 1'b0;
    total_next    = total;
    hold_res_next = hold_res;
    unique case (state)
      S_CLEAR: begin
        busy_we = (32'(clr_addr) < MAX_SLOTS);
        busy_wa = SLOT_W'(clr_addr);
        live_we = (32'(clr_addr) < MAX_IDS);
        id_wa   = ID_W'(clr_addr);
        if (32'(clr_addr) == CLR_N - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          busy_ra = head_hash_idx;
          case (q_item.kind)
            ohpc_pkg::KIND_INSERT: state_next = S_WALK;
            ohpc_pkg::KIND_DELETE: state_next = S_DEL;
            default: begin
              hold_res_next = '{probes_passed: '0, slot: '0,
                                status: q_item.status, total: total};
              state_next    = S_HOLD;
            end
          endcase
        end
      end
      S_DEL: begin
        if (!live_q) begin
          hold_res_next = '{probes_passed: '0, slot: '0,
                            status: ohpc_pkg::ST_BAD_ID, total: total};
        end else begin
          live_we       = 1'b1;
          busy_we       = 1'b1;
          busy_wa       = idslot_q;
          hold_res_next = '{probes_passed: '0, slot: SLOTF_W'(idslot_q),
                            status: ohpc_pkg::ST_OK, total: total};
        end
        state_next = S_HOLD;
      end
      S_WALK: begin
        if (!busy_q) begin
          busy_we       = 1'b1;
          busy_wd       = 1'b1;
          live_we       = 1'b1;
          live_wd       = 1'b1;
          idslot_we     = 1'b1;
          total_next    = total_sat;
          hold_res_next = '{probes_passed: passed_sat, slot: SLOTF_W'(pos_chk),
                            status: ohpc_pkg::ST_OK, total: total_sat};
          state_next    = S_HOLD;
        end else if (pos_nxt == home) begin
          hold_res_next = '{probes_passed: '0, slot: '0,
                            status: ohpc_pkg::ST_FULL, total: total};
          state_next    = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid || pop) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk registers and result staging.
  always_ff @(posedge clk) begin
    hold_res <= hold_res_next;
    if (q_pop) begin
      pos_chk <= head_hash_idx;
      home    <= head_hash_idx;
      passed  <= '0;
      cur_id  <= head_id_idx;
    end else if (state == S_WALK && busy_q) begin
      pos_chk <= pos_nxt;
      passed  <= passed + 1'b1;
    end
    if (out_load) begin
      res <= hold_res;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
    busy_q <= busy_mem[busy_ra];
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[id_wa] <= live_wd;
    end
    live_q <= live_mem[id_ra];
  end

  always_ff @(posedge clk) begin
    if (idslot_we) begin
      idslot_mem[id_wa] <= pos_chk;
    end
    idslot_q <= idslot_mem[id_ra];
  end

  assign clearing = (state == S_CLEAR);
  assign empty    = !out_valid;

endmodule

// ===== src/open_addressing_hash_probe_counter.sv =====
// The probe engine works on one word at a time (insert, delete or reject) and
// makes one slot-table read per probe; a two-word input queue keeps accepting
// words meanwhile until it is full.
// Reset: a clearing pass over max(MAX_SLOTS, MAX_IDS) entries holds full high; every
// configuration write then refreshes the probe step, with full high too.
`timescale 1ns / 1ps

module open_addressing_hash_probe_counter #(
  parameter int MAX_SLOTS = ohpc_pkg::DEF_MAX_SLOTS,
  parameter int MAX_IDS   = ohpc_pkg::DEF_MAX_IDS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  op,
  input  logic [ohpc_pkg::ID_FIELD_W-1:0]       id,
  input  logic [ohpc_pkg::HASH_FIELD_W-1:0]     hash,
  input  logic                                  pop,
  output logic                                  empty,
  output logic [ohpc_pkg::PASSED_FIELD_W-1:0]   probes_passed,
  output logic [ohpc_pkg::SLOT_FIELD_W-1:0]     slot,
  output logic [1:0]                            status,
  output logic [ohpc_pkg::TOTAL_W-1:0]          total_passed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ohpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ohpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Width of an effective table size, of a slot index, and of an id index.
  localparam int SZ_W   = $clog2(MAX_SLOTS + 1);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int ID_W   = $clog2(MAX_IDS);

  logic [ohpc_pkg::TABLE_SIZE_W-1:0] table_size;
  logic [ohpc_pkg::PROBE_STEP_W-1:0] probe_step;
  logic [SZ_W-1:0]                   eff_size;
  logic [SLOT_W-1:0]                 step;
  logic                              step_busy;
  logic                              clearing;
  logic                              cfg_write;

  logic              q_valid;
  logic              q_pop;
  ohpc_pkg::item_t   q_item;
  ohpc_pkg::result_t res;

  // The configuration port never stalls. Writes must arrive only while the block is idle;
  // the block does not enforce it (the user must), so registers feed the datapath directly.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= ohpc_pkg::TABLE_SIZE_RESET;
      probe_step <= ohpc_pkg::PROBE_STEP_RESET;
    end else if (cfg_write) begin
      unique case (ohpc_pkg::cfg_reg_t'(cfg_index))
        ohpc_pkg::CFG_TABLE_SIZE: table_size <= cfg_data;
        ohpc_pkg::CFG_PROBE_STEP: probe_step <= cfg_data[ohpc_pkg::PROBE_STEP_W-1:0];
      endcase
    end
  end

  // The size in use is the programmed size clamped to the table's physical
  // range, so a bad setting can never index past the slot memory.
  always_comb begin
    if (32'(table_size) < ohpc_pkg::MIN_SIZE) begin
      eff_size = SZ_W'(ohpc_pkg::MIN_SIZE);
    end else if (32'(table_size) > MAX_SLOTS) begin
      eff_size = SZ_W'(MAX_SLOTS);
    end else begin
      eff_size = SZ_W'(table_size);
    end
  end

  // The probe step is reduced modulo the size once per configuration write,
  // by a bit-serial remainder unit, so the probe walk needs only one
  // compare-and-subtract per slot.
  ohpc_step_mod #(
    .SZ_W   (SZ_W),
    .SLOT_W (SLOT_W)
  ) u_step_mod (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_write),
    .probe_step (probe_step),
    .eff_size   (eff_size),
    .step       (step),
    .busy       (step_busy)
  );

  // The front classifies each word (insert, delete or a rejection) and
  // queues it. It holds off new words while the tables are being cleared or
  // the step is being recomputed.
  ohpc_front #(
    .MAX_IDS (MAX_IDS),
    .SZ_W    (SZ_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .op       (op),
    .id       (id),
    .hash     (hash),
    .eff_size (eff_size),
    .hold     (clearing || step_busy),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back owns the slot, id and liveness memories, walks the probe
  // sequence one slot per cycle, keeps the saturating total and holds the
  // result register that the output side pops.
  ohpc_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_IDS   (MAX_IDS),
    .SZ_W      (SZ_W),
    .SLOT_W    (SLOT_W),
    .ID_W      (ID_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .eff_size (eff_size),
    .step     (step),
    .clearing (clearing),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign probes_passed = res.probes_passed;
  assign slot          = res.slot;
  assign status        = res.status;
  assign total_passed  = res.total;

endmodule

// ===== src/ohpc_checker.sv =====
`timescale 1ns / 1ps

module ohpc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  full,
  input logic                                  pop,
  input logic                                  empty,
  input logic [ohpc_pkg::PASSED_FIELD_W-1:0]   probes_passed,
  input logic [ohpc_pkg::SLOT_FIELD_W-1:0]     slot,
  input logic [1:0]                            status,
  input logic [ohpc_pkg::TOTAL_W-1:0]          total_passed
);

  // Reset starts the clearing pass: nothing is taken and nothing is shown.
  a_reset_blocks: assert property (@(posedge clk) rst |=> full && empty)
    else $error("full or empty wrong after reset");

  // The running total never decreases from one result word to the next.
  a_total_monotone: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> (empty || total_passed >= $past(total_passed)))
    else $error("running total decreased");

  // Any failure reports no probes and no slot.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ohpc_pkg::ST_OK) |-> (probes_passed == '0 && slot == '0))
    else $error("failed word carries a slot or probe count");

  // The total already includes the probes of a successful insert.
  a_total_covers: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ohpc_pkg::ST_OK) |->
      (total_passed >= ohpc_pkg::TOTAL_W'(probes_passed)))
    else $error("total below probe count");

  // A waiting result word holds until it is popped.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(slot) && $stable(total_passed)))
    else $error("result word changed while waiting");

endmodule

bind open_addressing_hash_probe_counter ohpc_checker u_ohpc_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .pop           (pop),
  .empty         (empty),
  .probes_passed (probes_passed),
  .slot          (slot),
  .status        (status),
  .total_passed  (total_passed)
);
